[hw/rtl/i2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2r_pkg;

  localparam int ValueW   = 12;
  localparam int SymW     = 3;
  localparam int StepW    = 4;
  localparam int NumSteps = 13;

  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  localparam logic [SymW-1:0] SYM_I = 3'd0;
  localparam logic [SymW-1:0] SYM_V = 3'd1;
  localparam logic [SymW-1:0] SYM_X = 3'd2;
  localparam logic [SymW-1:0] SYM_L = 3'd3;
  localparam logic [SymW-1:0] SYM_C = 3'd4;
  localparam logic [SymW-1:0] SYM_D = 3'd5;
  localparam logic [SymW-1:0] SYM_M = 3'd6;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } i2r_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } i2r_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic emit_last;
  } i2r_sts_t;

  function automatic logic [ValueW-1:0] step_value(input logic [StepW-1:0] idx);
    logic [ValueW-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [SymW-1:0] step_first(input logic [StepW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd0:    s = SYM_M;
      4'd1:    s = SYM_C;
      4'd2:    s = SYM_D;
      4'd3:    s = SYM_C;
      4'd4:    s = SYM_C;
      4'd5:    s = SYM_X;
      4'd6:    s = SYM_L;
      4'd7:    s = SYM_X;
      4'd8:    s = SYM_X;
      4'd9:    s = SYM_I;
      4'd10:   s = SYM_V;
      4'd11:   s = SYM_I;
      default: s = SYM_I;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] step_second(input logic [StepW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd1:    s = SYM_M;
      4'd3:    s = SYM_D;
      4'd5:    s = SYM_C;
      4'd7:    s = SYM_L;
      4'd9:    s = SYM_X;
      4'd11:   s = SYM_V;
      default: s = SYM_I;
    endcase
    return s;
  endfunction

  function automatic logic step_is_pair(input logic [StepW-1:0] idx);
    logic p;
    case (idx)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: p = 1'b1;
      default:                             p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/i2r_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2r_ctrl
  import i2r_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire i2r_sts_t sts_i,
  output i2r_cmd_t      cmd_o
);

  i2r_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/i2r_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2r_datapath
  import i2r_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] value_i,
  input  wire i2r_cmd_t          cmd_i,
  output i2r_sts_t               sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SymW-1:0]        symbol_o,
  output logic                   last_o,
  output logic                   out_of_range_o
);

  logic [ValueW-1:0] rem_q, rem_d;
  logic              pending_q, pending_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              last_q, last_d;
  logic              oor_q, oor_d;

  logic [StepW-1:0]  step;
  logic [ValueW-1:0] rem_sub;
  logic              sub_zero;

  // Largest step value that still fits in the remainder. Greedy order makes
  // this the same step the sequence would reach by walking the table.
  always_comb begin
    step = StepW'(NumSteps - 1);
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (rem_q >= step_value(StepW'(i))) begin
        step = StepW'(i);
      end
    end
  end

  assign rem_sub  = rem_q - step_value(step);
  assign sub_zero = (rem_sub == '0);

  always_comb begin
    rem_d       = rem_q;
    pending_d   = pending_q;
    err_d       = err_q;
    sym_d       = sym_q;
    last_d      = last_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    // Output-free status and the last mark the next emit would produce.
    sts_o.out_free  = ~out_valid_q | out_ready_i;
    sts_o.emit_last = 1'b0;
    if (err_q) begin
      sts_o.emit_last = 1'b1;
    end else if (pending_q) begin
      sts_o.emit_last = sub_zero;
    end else if (!step_is_pair(step)) begin
      sts_o.emit_last = sub_zero;
    end

    if (cmd_i.load) begin
      rem_d     = value_i;
      pending_d = 1'b0;
      err_d     = (value_i == '0) || (value_i > MaxValue);
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      last_d      = sts_o.emit_last;
      oor_d       = err_q;
      if (err_q) begin
        sym_d = SYM_I;
      end else if (pending_q) begin
        // Second half of a subtractive pair; the step is retired now.
        sym_d     = step_second(step);
        rem_d     = rem_sub;
        pending_d = 1'b0;
      end else if (step_is_pair(step)) begin
        sym_d     = step_first(step);
        pending_d = 1'b1;
      end else begin
        sym_d = step_first(step);
        rem_d = rem_sub;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pending_q   <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pending_q   <= pending_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    oor_q  <= oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = sym_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;

  // An error result is a single item carrying symbol I.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oor_q |-> last_q && (sym_q == SYM_I))
    else $error("out_of_range result is not a lone symbol-I item");

  // A pending pair half always has its value still inside the remainder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q && !err_q |-> (rem_q != '0) && step_is_pair(step))
    else $error("pending pair half without a matching remainder");

  // A valid result never carries the unused symbol code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sym_q != 3'd7))
    else $error("result carries an undefined symbol code");

  // Emitting a non-last symbol must leave work to do.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !sts_o.emit_last |=> !err_q && ((rem_q != '0) || pending_q))
    else $error("numeral ended without a last mark");

endmodule

`default_nettype wire

[hw/rtl/integer_to_roman.sv]
// Integer to Roman numeral converter.
// Input channel: in_valid_i / in_ready_o with value_i, a 12-bit unsigned
// integer. Output channel: out_valid_o / out_ready_i with symbol_o
// (0=I 1=V 2=X 3=L 4=C 5=D 6=M), last_o and out_of_range_o.
// Each accepted item yields its numeral largest symbol first, one symbol
// per result item; subtractive pairs such as CM come out as two items and
// the final item of a numeral has last_o set. Values of 0 or above 3999
// yield a single item with out_of_range_o set, symbol I and last_o set.
// A numeral has at most 15 symbols. The value is first loaded into a
// remainder-and-step datapath, which then issues one symbol per cycle
// into the single output register while the receiver does not stall.
// in_ready_o is high whenever no conversion is running, even while the
// final symbol still waits in the output register.
// A receiver stall simply holds the output register and the conversion.
// Reset clears the controller and the output valid; nothing is kept
// between items.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman
  import i2r_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SymW-1:0]        symbol_o,
  output logic                   last_o,
  output logic                   out_of_range_o
);

  i2r_cmd_t cmd;
  i2r_sts_t sts;

  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2r_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire

[dv/integer_to_roman_tb.sv]
`timescale 1ns / 1ps

module integer_to_roman_tb;
  import i2r_pkg::*;

  localparam int unsigned RandomItems = 320;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            out_of_range;
  } roman_sym_t;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } idle_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [SymW-1:0]   symbol_o;
  logic              last_o;
  logic              out_of_range_o;

  logic [ValueW-1:0] value_q[$];
  roman_sym_t        numeral_q[$];
  roman_sym_t        want_sym;
  int unsigned       num_items;
  int unsigned       in_cnt = 0;
  int unsigned       err_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       hold_cnt = 0;
  logic              hold_done = 1'b0;
  idle_phase_e       phase;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;

  int unsigned directed_vals [24] = '{
    0, 1, 3, 4, 5, 9, 14, 40, 49, 90, 400, 444,
    500, 900, 999, 1000, 1365, 1994, 2048, 2730, 3888, 3999, 4000, 4095
  };

  integer_to_roman dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // Works out the numeral one decimal place at a time, which gives the same
  // symbols as greedy subtraction over the thirteen step values.
  function automatic void predict_numeral(input logic [ValueW-1:0] v);
    logic [SymW-1:0] syms[$];
    logic [SymW-1:0] one_s;
    logic [SymW-1:0] five_s;
    logic [SymW-1:0] ten_s;
    roman_sym_t      r;
    int unsigned     rest;
    int unsigned     scale;
    int unsigned     d;
    int              p;
    if (v == '0 || v > MaxValue) begin
      r.symbol = SYM_I;
      r.last = 1'b1;
      r.out_of_range = 1'b1;
      numeral_q = {numeral_q, r};
      return;
    end
    rest = v;
    scale = 1000;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          one_s = SYM_M; five_s = SYM_M; ten_s = SYM_M;
        end
        1: begin
          one_s = SYM_C; five_s = SYM_D; ten_s = SYM_M;
        end
        2: begin
          one_s = SYM_X; five_s = SYM_L; ten_s = SYM_C;
        end
        default: begin
          one_s = SYM_I; five_s = SYM_V; ten_s = SYM_X;
        end
      endcase
      d = rest / scale;
      rest = rest % scale;
      if (d == 9) begin
        syms = {syms, one_s};
        syms = {syms, ten_s};
      end else if (d == 4) begin
        syms = {syms, one_s};
        syms = {syms, five_s};
      end else begin
        if (d >= 5) syms = {syms, five_s};
        repeat (d % 5) syms = {syms, one_s};
      end
      scale = scale / 10;
    end
    foreach (syms[k]) begin
      r.symbol = syms[k];
      r.last = (k == syms.size() - 1);
      r.out_of_range = 1'b0;
      numeral_q = {numeral_q, r};
    end
  endfunction

  always_comb begin
    if (in_cnt < 90) phase = PH_STEADY;
    else if (in_cnt < 170) phase = PH_SEND_GAPS;
    else if (in_cnt < 250) phase = PH_RECV_STALLS;
    else if (in_cnt < 310) phase = PH_BOTH;
    else phase = PH_STEADY;
    case (phase)
      PH_SEND_GAPS: begin
        send_gap_pct = 61; recv_stall_pct = 0;
      end
      PH_RECV_STALLS: begin
        send_gap_pct = 0; recv_stall_pct = 61;
      end
      PH_BOTH: begin
        send_gap_pct = 8; recv_stall_pct = 8;
      end
      default: begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
    endcase
  end

  // Sender: a new item is offered only once the current one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_numeral(value_i);
        in_cnt <= in_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (value_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          value_i <= value_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off early on lets the block back up into its
  // input while the sender keeps offering items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && in_cnt >= 50) begin
      hold_done <= 1'b1;
      hold_cnt <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (numeral_q.size() == 0) begin
        $error("unexpected item: symbol %0d last %0b out_of_range %0b",
               symbol_o, last_o, out_of_range_o);
        err_cnt++;
      end else begin
        want_sym = numeral_q.pop_front();
        if (symbol_o !== want_sym.symbol) begin
          $error("symbol: expected %0d, got %0d", want_sym.symbol, symbol_o);
          err_cnt++;
        end
        if (last_o !== want_sym.last) begin
          $error("last: expected %0b, got %0b", want_sym.last, last_o);
          err_cnt++;
        end
        if (out_of_range_o !== want_sym.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b",
                 want_sym.out_of_range, out_of_range_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned v;
    foreach (directed_vals[i]) value_q = {value_q, ValueW'(directed_vals[i])};
    repeat (RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        v = 0;
      end else if (roll < 10) begin
        v = $urandom_range(4000, 4095);
      end else if (roll < 25) begin
        // Long numerals keep the output side busy.
        v = $urandom_range(0, 3) * 1000 + $urandom_range(7, 8) * 100
          + $urandom_range(7, 8) * 10 + $urandom_range(7, 8);
      end else begin
        v = $urandom_range(1, 3999);
      end
      value_q = {value_q, ValueW'(v)};
    end
    num_items = value_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (in_cnt != num_items || numeral_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && numeral_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
